/* src/izhikevich_neuron_step_defines.svh */
// Assertion macros shared by the neuron step block.
`ifndef IZHIKEVICH_NEURON_STEP_DEFINES_SVH
`define IZHIKEVICH_NEURON_STEP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define IZN_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("izn assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define IZN_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("izn assertion failed");

`endif

/* src/izn_pkg.sv */
// Types, constants and saturation helper for the neuron step block.
package izn_pkg;

  localparam int FRAC_BITS = 24;
  localparam int ACC_W     = 44;
  localparam int CNT_W     = 10;
  localparam int IDX_W     = 8;

  localparam logic [CNT_W-1:0] REFRACT_TICKS = CNT_W'(20);

  localparam logic [IDX_W-1:0] REG_QUAD_GAIN         = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_LIN_GAIN          = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_CONST_DRIVE       = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_RECOVERY_RATE     = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_RECOVERY_COUPLING = IDX_W'(4);
  localparam logic [IDX_W-1:0] REG_SPIKE_JUMP        = IDX_W'(5);
  localparam logic [IDX_W-1:0] REG_PEAK_LEVEL        = IDX_W'(6);
  localparam logic [IDX_W-1:0] REG_RESET_LEVEL       = IDX_W'(7);

  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_REINIT = 1'b1;

  typedef struct packed {
    logic               op;
    logic signed [31:0] activation_step;
    logic signed [31:0] current_step;
    logic signed [31:0] init_membrane;
    logic signed [31:0] init_recovery;
  } in_t;

  typedef struct packed {
    logic signed [31:0] membrane_out;
    logic               spiked;
    logic signed [31:0] recovery_out;
  } out_t;

  typedef struct packed {
    logic signed [31:0] quad_gain;
    logic signed [31:0] lin_gain;
    logic signed [31:0] const_drive;
    logic signed [31:0] recovery_rate;
    logic signed [31:0] recovery_coupling;
    logic signed [31:0] spike_jump;
    logic signed [31:0] peak_level;
    logic signed [31:0] reset_level;
  } cfg_t;

  // Operand load for the shared multiplier.
  typedef struct packed {
    logic               load;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } mul_ctl_t;

  // Clamps a wide signed value to the 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
    logic signed [31:0] r;
    if ((&x[ACC_W-1:31]) || !(|x[ACC_W-1:31])) begin
      r = x[31:0];
    end else if (x[ACC_W-1]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

endpackage

/* src/izn_cfg.sv */
// Configuration register file of the neuron step block.
module izn_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [izn_pkg::IDX_W-1:0]  cfg_index,
  input  logic [31:0]                cfg_data,
  output izn_pkg::cfg_t              cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        izn_pkg::REG_QUAD_GAIN:         cfg.quad_gain         <= cfg_data;
        izn_pkg::REG_LIN_GAIN:          cfg.lin_gain          <= cfg_data;
        izn_pkg::REG_CONST_DRIVE:       cfg.const_drive       <= cfg_data;
        izn_pkg::REG_RECOVERY_RATE:     cfg.recovery_rate     <= cfg_data;
        izn_pkg::REG_RECOVERY_COUPLING: cfg.recovery_coupling <= cfg_data;
        izn_pkg::REG_SPIKE_JUMP:        cfg.spike_jump        <= cfg_data;
        izn_pkg::REG_PEAK_LEVEL:        cfg.peak_level        <= cfg_data;
        izn_pkg::REG_RESET_LEVEL:       cfg.reset_level       <= cfg_data;
        default: begin
          // Indexes past the last register are ignored.
        end
      endcase
    end
  end

endmodule

/* src/izn_mul.sv */
// Shared 32x32 signed multiplier with registered operands and product.
module izn_mul (
  input  logic                      clk,
  input  izn_pkg::mul_ctl_t         ctl,
  output logic signed [63:0]        prod
);

  logic signed [31:0] opa;
  logic signed [31:0] opb;

  // The product register is refreshed every cycle from the operand registers, so a
  // result passes through the operand registers and then the product register.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      opa <= ctl.a;
      opb <= ctl.b;
    end
    prod <= opa * opb;
  end

endmodule

/* src/izhikevich_neuron_step.sv */
// Izhikevich neuron: one Euler step per tick transaction on a shared multiplier.
//
// Each input transaction is a tick (one forward-Euler step) or a reinit. The block
// takes one transaction at a time and holds in_stall high while it works. A reinit
// or refractory tick passes through the prep and done states, a tick that spikes
// also through the compare state, and an integrating tick through every state. The
// integrating tick is the longest because the single 32x32 multiplier forms v*v,
// lin_gain*v, quad_gain*v^2, recovery_coupling*v' and recovery_rate*diff in turn,
// each product registered. The result sits in an output register; if it has not
// been taken when the next result is finished, the block waits until it is.
// Configuration registers reset to zero; the user must write them only while the
// block is idle, and the block does not enforce this.
`include "izhikevich_neuron_step_defines.svh"

module izhikevich_neuron_step (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  izn_pkg::in_t               in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output izn_pkg::out_t              out_data,
  input  logic                       cfg_we,
  input  logic [izn_pkg::IDX_W-1:0]  cfg_index,
  input  logic [31:0]                cfg_data
);

  typedef enum logic [12:0] {
    ST_IDLE = 13'b0000000000001,
    ST_PREP = 13'b0000000000010,
    ST_CMP  = 13'b0000000000100,
    ST_MA   = 13'b0000000001000,
    ST_MB   = 13'b0000000010000,
    ST_MC   = 13'b0000000100000,
    ST_MD   = 13'b0000001000000,
    ST_VN   = 13'b0000010000000,
    ST_ME   = 13'b0000100000000,
    ST_MF   = 13'b0001000000000,
    ST_MG   = 13'b0010000000000,
    ST_MH   = 13'b0100000000000,
    ST_DONE = 13'b1000000000000
  } state_t;

  state_t state;

  izn_pkg::cfg_t     cfg;
  izn_pkg::in_t      req;
  izn_pkg::mul_ctl_t mul_ctl;

  logic signed [63:0]                   prod;
  logic signed [39:0]                   prod_q;
  logic signed [izn_pkg::ACC_W-1:0]     acc;
  logic signed [31:0]                   membrane;
  logic signed [31:0]                   recovery_scaled;
  logic signed [31:0]                   pending_activation;
  logic [izn_pkg::CNT_W-1:0]            refractory_left;
  logic signed [31:0]                   vm;
  logic                                 fired;
  logic signed [31:0]                   vn;
  logic                                 spike_now;
  logic                                 out_free;

  izn_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  izn_mul u_mul (
    .clk  (clk),
    .ctl  (mul_ctl),
    .prod (prod)
  );

  // Floor of the product over 2^24 is the upper bits of the exact product.
  assign prod_q    = prod[63:izn_pkg::FRAC_BITS];
  assign vn        = izn_pkg::sat32(acc);
  assign spike_now = (vm > cfg.peak_level);
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != ST_IDLE);

  // Multiplier operand schedule.
  always_comb begin
    mul_ctl = '0;
    unique case (state)
      ST_CMP: begin
        mul_ctl.load = 1'b1;
        mul_ctl.a    = vm;
        mul_ctl.b    = vm;
      end
      ST_MA: begin
        mul_ctl.load = 1'b1;
        mul_ctl.a    = cfg.lin_gain;
        mul_ctl.b    = vm;
      end
      ST_MB: begin
        // The product now holds v*v; the square is clamped before scaling.
        mul_ctl.load = 1'b1;
        mul_ctl.a    = cfg.quad_gain;
        mul_ctl.b    = izn_pkg::sat32(izn_pkg::ACC_W'(prod_q));
      end
      ST_VN: begin
        mul_ctl.load = 1'b1;
        mul_ctl.a    = cfg.recovery_coupling;
        mul_ctl.b    = vn;
      end
      ST_MF: begin
        mul_ctl.load = 1'b1;
        mul_ctl.a    = cfg.recovery_rate;
        mul_ctl.b    = izn_pkg::sat32(izn_pkg::ACC_W'(prod_q)
                                      - izn_pkg::ACC_W'(recovery_scaled));
      end
      default: begin
        mul_ctl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      membrane           <= '0;
      recovery_scaled    <= '0;
      pending_activation <= '0;
      refractory_left    <= '0;
      out_valid          <= 1'b0;
    end else begin
      // A result that finishes as the old one is taken reloads the register below.
      if (out_valid && !out_stall && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            req   <= in_data;
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          fired <= 1'b0;
          if (req.op == izn_pkg::OP_REINIT) begin
            membrane           <= req.init_membrane;
            recovery_scaled    <= req.init_recovery;
            pending_activation <= '0;
            refractory_left    <= '0;
            state              <= ST_DONE;
          end else if (refractory_left != '0) begin
            refractory_left    <= refractory_left - izn_pkg::CNT_W'(1);
            membrane           <= cfg.reset_level;
            pending_activation <= izn_pkg::sat32(izn_pkg::ACC_W'(pending_activation)
                                                 + izn_pkg::ACC_W'(req.activation_step));
            state              <= ST_DONE;
          end else begin
            vm <= izn_pkg::sat32(izn_pkg::ACC_W'(membrane)
                                 + izn_pkg::ACC_W'(pending_activation)
                                 + izn_pkg::ACC_W'(req.activation_step));
            pending_activation <= '0;
            state              <= ST_CMP;
          end
        end
        ST_CMP: begin
          if (spike_now) begin
            membrane        <= cfg.reset_level;
            recovery_scaled <= izn_pkg::sat32(izn_pkg::ACC_W'(recovery_scaled)
                                              + izn_pkg::ACC_W'(cfg.spike_jump));
            refractory_left <= izn_pkg::REFRACT_TICKS;
            fired           <= 1'b1;
            state           <= ST_DONE;
          end else begin
            // Terms that need no product are summed up front.
            acc   <= izn_pkg::ACC_W'(vm) + izn_pkg::ACC_W'(req.current_step)
                     + izn_pkg::ACC_W'(cfg.const_drive)
                     - izn_pkg::ACC_W'(recovery_scaled);
            state <= ST_MA;
          end
        end
        ST_MA: begin
          state <= ST_MB;
        end
        ST_MB: begin
          state <= ST_MC;
        end
        ST_MC: begin
          acc   <= acc + izn_pkg::ACC_W'(prod_q);
          state <= ST_MD;
        end
        ST_MD: begin
          acc   <= acc + izn_pkg::ACC_W'(prod_q);
          state <= ST_VN;
        end
        ST_VN: begin
          membrane <= vn;
          state    <= ST_ME;
        end
        ST_ME: begin
          state <= ST_MF;
        end
        ST_MF: begin
          state <= ST_MG;
        end
        ST_MG: begin
          state <= ST_MH;
        end
        ST_MH: begin
          recovery_scaled <= izn_pkg::sat32(izn_pkg::ACC_W'(recovery_scaled)
                                            + izn_pkg::ACC_W'(prod_q));
          state           <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid              <= 1'b1;
            out_data.membrane_out  <= membrane;
            out_data.spiked        <= fired;
            out_data.recovery_out  <= recovery_scaled;
            state                  <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `IZN_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)
  `IZN_ASSERT_NOW(a_refract_bound, clk, rst, 1'b1, refractory_left <= izn_pkg::REFRACT_TICKS)
  `IZN_ASSERT_NEXT(a_spike_loads_count, clk, rst, state == ST_CMP && spike_now,
                   refractory_left == izn_pkg::REFRACT_TICKS && fired)
  `IZN_ASSERT_NEXT(a_done_delivers, clk, rst, state == ST_DONE && out_free,
                   out_valid && !in_stall)

endmodule

/* test/tb_top.sv */
// Self-checking testbench for the Izhikevich neuron step block.
`timescale 1ns / 100ps

module tb_top;

  localparam int     SETTLE_CYCLES = 20;
  localparam int     HOLD_CYCLES   = 300;
  localparam int     DRAIN_LIMIT   = 20000;
  localparam longint SAT_HI        = 64'sd2147483647;
  localparam longint SAT_LO        = -64'sd2147483648;

  // Indexes past the register file; writes to them must change nothing.
  localparam logic [izn_pkg::IDX_W-1:0] REG_PAST_END   = izn_pkg::IDX_W'(8);
  localparam logic [izn_pkg::IDX_W-1:0] REG_LAST_INDEX = '1;

  // Plausible neuron settings in Q8.24 for a 0.1 ms step.
  localparam int Q_ONE       = 32'sh0100_0000;
  localparam int QUAD_NOM    = 32'sh0400_0000;
  localparam int LIN_NOM     = 32'sh0080_0000;
  localparam int DRIVE_NOM   = 234881;
  localparam int RATE_NOM    = 33554;
  localparam int COUPLE_NOM  = 335544;
  localparam int JUMP_NOM    = 13422;
  localparam int PEAK_NOM    = 503316;
  localparam int RESET_NOM   = -1090519;
  localparam int ACT_LO      = -167772;
  localparam int ACT_HI      = 503316;
  localparam int CUR_SPAN    = 167772;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_stall;
  izn_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  izn_pkg::out_t out_data;
  logic          cfg_we = 1'b0;
  logic [izn_pkg::IDX_W-1:0] cfg_index = '0;
  logic [31:0]   cfg_data = '0;

  logic        steady = 1'b0;
  logic        hold_request = 1'b0;
  int          hold_left = 0;
  int          mismatches = 0;

  // Predictor state, tracked alongside the block.
  izn_pkg::cfg_t             neuron_cfg = '0;
  logic signed [31:0]        neuron_v = '0;
  logic signed [31:0]        neuron_w = '0;
  logic signed [31:0]        neuron_pending = '0;
  logic [izn_pkg::CNT_W-1:0] neuron_refract = '0;
  izn_pkg::out_t             predicted_states[$];

  izhikevich_neuron_step dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic logic signed [31:0] clamp32(input longint x);
    if (x > SAT_HI) return 32'sh7FFF_FFFF;
    if (x < SAT_LO) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  // Exact Q8.24 product, rounded towards minus infinity.
  function automatic longint fx_mul(input logic signed [31:0] a, input logic signed [31:0] b);
    return (longint'(a) * longint'(b)) >>> izn_pkg::FRAC_BITS;
  endfunction

  function automatic izn_pkg::out_t neuron_euler_step(input izn_pkg::in_t it);
    izn_pkg::out_t      res;
    logic signed [31:0] vm;
    logic signed [31:0] sq;
    logic signed [31:0] vn;
    logic signed [31:0] diff;
    longint             sum;
    res.spiked = 1'b0;
    if (it.op == izn_pkg::OP_REINIT) begin
      neuron_v       = it.init_membrane;
      neuron_w       = it.init_recovery;
      neuron_pending = '0;
      neuron_refract = '0;
    end else if (neuron_refract != '0) begin
      neuron_refract = neuron_refract - izn_pkg::CNT_W'(1);
      neuron_v       = neuron_cfg.reset_level;
      neuron_pending = clamp32(longint'(neuron_pending) + longint'(it.activation_step));
    end else begin
      vm = clamp32(longint'(neuron_v) + longint'(neuron_pending)
                   + longint'(it.activation_step));
      neuron_pending = '0;
      if (vm > neuron_cfg.peak_level) begin
        neuron_v       = neuron_cfg.reset_level;
        neuron_w       = clamp32(longint'(neuron_w) + longint'(neuron_cfg.spike_jump));
        neuron_refract = izn_pkg::REFRACT_TICKS;
        res.spiked     = 1'b1;
      end else begin
        sq   = clamp32(fx_mul(vm, vm));
        sum  = longint'(vm) + longint'(it.current_step) + fx_mul(neuron_cfg.quad_gain, sq)
               + fx_mul(neuron_cfg.lin_gain, vm) + longint'(neuron_cfg.const_drive)
               - longint'(neuron_w);
        vn   = clamp32(sum);
        diff = clamp32(fx_mul(neuron_cfg.recovery_coupling, vn) - longint'(neuron_w));
        neuron_v = vn;
        neuron_w = clamp32(longint'(neuron_w) + fx_mul(neuron_cfg.recovery_rate, diff));
      end
    end
    res.membrane_out = neuron_v;
    res.recovery_out = neuron_w;
    return res;
  endfunction

  function automatic int span_value(input int lo, input int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // Mostly values in a working range, now and then any 32-bit pattern.
  function automatic logic [31:0] field_value(input int lo, input int hi);
    if ($urandom_range(99) < 12) return $urandom;
    return span_value(lo, hi);
  endfunction

  function automatic izn_pkg::in_t rand_item();
    izn_pkg::in_t it;
    it.op              = ($urandom_range(99) < 6) ? izn_pkg::OP_REINIT : izn_pkg::OP_TICK;
    it.activation_step = field_value(ACT_LO, ACT_HI);
    it.current_step    = field_value(-CUR_SPAN, CUR_SPAN);
    it.init_membrane   = field_value(RESET_NOM - CUR_SPAN, PEAK_NOM);
    it.init_recovery   = field_value(-CUR_SPAN, CUR_SPAN);
    return it;
  endfunction

  function automatic izn_pkg::cfg_t nominal_cfg();
    izn_pkg::cfg_t c;
    c.quad_gain         = QUAD_NOM;
    c.lin_gain          = LIN_NOM;
    c.const_drive       = DRIVE_NOM;
    c.recovery_rate     = RATE_NOM;
    c.recovery_coupling = COUPLE_NOM;
    c.spike_jump        = JUMP_NOM;
    c.peak_level        = PEAK_NOM;
    c.reset_level       = RESET_NOM;
    return c;
  endfunction

  function automatic int jitter(input int base);
    int spread;
    spread = ((base < 0) ? -base : base) / 2 + 1;
    return base - spread + int'($urandom_range(2 * spread));
  endfunction

  function automatic izn_pkg::cfg_t jittered_cfg();
    izn_pkg::cfg_t c;
    c.quad_gain         = jitter(QUAD_NOM);
    c.lin_gain          = jitter(LIN_NOM);
    c.const_drive       = jitter(DRIVE_NOM);
    c.recovery_rate     = jitter(RATE_NOM);
    c.recovery_coupling = jitter(COUPLE_NOM);
    c.spike_jump        = jitter(JUMP_NOM);
    c.peak_level        = jitter(PEAK_NOM);
    c.reset_level       = jitter(RESET_NOM);
    return c;
  endfunction

  function automatic logic [31:0] corner_value();
    case ($urandom_range(3))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic izn_pkg::cfg_t corner_cfg();
    izn_pkg::cfg_t c;
    c.quad_gain         = corner_value();
    c.lin_gain          = corner_value();
    c.const_drive       = corner_value();
    c.recovery_rate     = corner_value();
    c.recovery_coupling = corner_value();
    c.spike_jump        = corner_value();
    c.peak_level        = corner_value();
    c.reset_level       = corner_value();
    return c;
  endfunction

  function automatic izn_pkg::cfg_t uniform_cfg(input logic [31:0] value);
    izn_pkg::cfg_t c;
    c = {8{value}};
    return c;
  endfunction

  function automatic izn_pkg::in_t make_item(input logic op, input logic [31:0] act,
                                             input logic [31:0] cur, input logic [31:0] v0,
                                             input logic [31:0] w0);
    izn_pkg::in_t it;
    it.op              = op;
    it.activation_step = act;
    it.current_step    = cur;
    it.init_membrane   = v0;
    it.init_recovery   = w0;
    return it;
  endfunction

  task automatic write_one(input logic [izn_pkg::IDX_W-1:0] idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // Only called while the block is idle.
  task automatic load_regs(input izn_pkg::cfg_t c);
    write_one(izn_pkg::REG_QUAD_GAIN, c.quad_gain);
    write_one(izn_pkg::REG_LIN_GAIN, c.lin_gain);
    write_one(izn_pkg::REG_CONST_DRIVE, c.const_drive);
    write_one(izn_pkg::REG_RECOVERY_RATE, c.recovery_rate);
    write_one(izn_pkg::REG_RECOVERY_COUPLING, c.recovery_coupling);
    write_one(izn_pkg::REG_SPIKE_JUMP, c.spike_jump);
    write_one(izn_pkg::REG_PEAK_LEVEL, c.peak_level);
    write_one(izn_pkg::REG_RESET_LEVEL, c.reset_level);
    write_one(REG_PAST_END, $urandom);
    write_one(REG_LAST_INDEX, $urandom);
    cfg_we <= 1'b0;
    neuron_cfg = c;
  endtask

  task automatic send_item(input izn_pkg::in_t it);
    int gap;
    if (!steady && $urandom_range(99) < 35) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted_states.push_back(neuron_euler_step(it));
  endtask

  // Stops offering and waits for every outstanding result, up to a limit, then lets the block settle.
  task automatic wait_idle(input int limit);
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (predicted_states.size() != 0 && waited < limit) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_item(rand_item());
  endtask

  task automatic test_refractory();
    wait_idle(DRAIN_LIMIT);
    load_regs(nominal_cfg());
    send_item(make_item(izn_pkg::OP_REINIT, $urandom, $urandom, RESET_NOM, '0));
    send_item(make_item(izn_pkg::OP_TICK, Q_ONE, $urandom, $urandom, $urandom));
    // Refractory ticks: activation piles up and saturates; current is ignored.
    for (int i = 0; i < 20; i++) begin
      if (i < 2)
        send_item(make_item(izn_pkg::OP_TICK, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            $urandom, $urandom));
      else if (i < 4)
        send_item(make_item(izn_pkg::OP_TICK, 32'h8000_0000, 32'h8000_0000,
                            $urandom, $urandom));
      else
        send_item(make_item(izn_pkg::OP_TICK, span_value(ACT_LO, ACT_HI), $urandom,
                            $urandom, $urandom));
    end
    send_item(make_item(izn_pkg::OP_TICK, '0, '0, $urandom, $urandom));
  endtask

  task automatic test_extremes();
    send_item(make_item(izn_pkg::OP_REINIT, $urandom, $urandom,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_item(make_item(izn_pkg::OP_TICK, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0, '0));
    send_item(make_item(izn_pkg::OP_REINIT, $urandom, $urandom,
                        32'h8000_0000, 32'h8000_0000));
    send_item(make_item(izn_pkg::OP_TICK, 32'h8000_0000, 32'h8000_0000, '1, '1));
    send_item(make_item(izn_pkg::OP_TICK, '0, 32'h8000_0000, '0, '0));
  endtask

  task automatic test_random_phases();
    wait_idle(DRAIN_LIMIT);
    load_regs(nominal_cfg());
    steady <= 1'b1;
    send_random(150);
    steady <= 1'b0;
    send_random(250);

    wait_idle(DRAIN_LIMIT);
    load_regs(jittered_cfg());
    send_random(300);

    wait_idle(DRAIN_LIMIT);
    load_regs(uniform_cfg(32'h7FFF_FFFF));
    send_random(150);

    wait_idle(DRAIN_LIMIT);
    load_regs(uniform_cfg(32'h8000_0000));
    send_random(150);

    wait_idle(DRAIN_LIMIT);
    load_regs(uniform_cfg($urandom) ^ {$urandom, $urandom, $urandom, $urandom,
                                       $urandom, $urandom, $urandom, $urandom});
    send_random(200);

    wait_idle(DRAIN_LIMIT);
    load_regs(corner_cfg());
    send_random(200);

    wait_idle(DRAIN_LIMIT);
    load_regs(jittered_cfg());
    send_random(250);
  endtask

  // The receiver holds off for a long stretch while transactions keep coming.
  task automatic test_backpressure();
    wait_idle(DRAIN_LIMIT);
    load_regs(nominal_cfg());
    hold_request <= 1'b1;
    @(posedge clk);
    hold_request <= 1'b0;
    send_random(20);
  endtask

  task automatic test_drain_pause();
    send_random(30);
    wait_idle(DRAIN_LIMIT);
    send_random(30);
  endtask

  always @(posedge clk) begin
    if (hold_request) begin
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !steady && ($urandom_range(99) < 35);
    end
  end

  always @(posedge clk) begin : check_results
    izn_pkg::out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (predicted_states.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: result with nothing expected, membrane %h spiked %b recovery %h",
                   out_data.membrane_out, out_data.spiked, out_data.recovery_out);
      end else begin
        want = predicted_states.pop_front();
        if (out_data.membrane_out !== want.membrane_out || out_data.spiked !== want.spiked ||
            out_data.recovery_out !== want.recovery_out) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: membrane %h/%h spiked %b/%b recovery %h/%h %s",
                     $realtime, want.membrane_out, out_data.membrane_out, want.spiked,
                     out_data.spiked, want.recovery_out, out_data.recovery_out,
                     "(expected/actual)");
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_refractory();
    test_extremes();
    test_backpressure();
    test_drain_pause();
    test_random_phases();
    wait_idle(DRAIN_LIMIT);
    if (mismatches == 0 && predicted_states.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/izn_pkg.sv
src/izn_cfg.sv
src/izn_mul.sv
src/izhikevich_neuron_step.sv
test/tb_top.sv
